// ===== rtl/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Shared types, constants and the shaper table generator for the channel
// strip saturator.
// ----------------------------------------------------------------------------
`default_nettype none

package scss_pkg;

  localparam int SampleWidthDef = 24;
  localparam int CoeffWidthDef  = 16;
  localparam int ShaperDepthDef = 1024;

  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 24;
  localparam int SlewWidth    = 24;
  localparam int LevelWidth   = 17;
  localparam int RomWidth     = 18;

  localparam logic [CoeffWidthDef-1:0] HpCoeffRst = CoeffWidthDef'(655);
  localparam logic [SlewWidth-1:0]     SlewRst    = SlewWidth'(8388607);
  localparam logic [LevelWidth-1:0]    DriveRst   = LevelWidth'(0);
  localparam logic [LevelWidth-1:0]    Unity      = LevelWidth'(65536);
  localparam logic [LevelWidth-1:0]    GainRst    = LevelWidth'(65536);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_HP_COEFF = 2'd0,
    CFG_SLEW     = 2'd1,
    CFG_DRIVE    = 2'd2,
    CFG_GAIN     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_MUL_HP = 3'd0,
    STEP_HP     = 3'd1,
    STEP_IDX    = 3'd2,
    STEP_ROM    = 3'd3,
    STEP_BLEND  = 3'd4,
    STEP_SLEW   = 3'd5,
    STEP_GAIN   = 3'd6,
    STEP_DONE   = 3'd7
  } step_e;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
    logic  phase;
  } lane_ctl_t;

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic [63:0] KQ30      = 64'd1345735808;
  localparam logic [63:0] EntryMax  = 64'd262143;

  // shift-subtract division, evaluated at elaboration only
  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi/2 t^2) / (k t) in q1.17, t = i / (depth-1)
  function automatic logic [RomWidth-1:0] shaper_entry(int unsigned i, int unsigned depth);
    logic [63:0] t, p, z, z2, term, s, kt, e;
    logic [63:0] dens [5];
    dens[0] = 64'd110;
    dens[1] = 64'd72;
    dens[2] = 64'd42;
    dens[3] = 64'd20;
    dens[4] = 64'd6;
    if (i == 0) return '0;
    t  = udiv(64'(i) << 30, 64'(depth - 1));
    p  = (t * t) >> 30;
    z  = (PiHalfQ30 * p) >> 30;
    z2 = (z * z) >> 30;
    term = Q30One;
    for (int k = 0; k < 5; k++) begin
      term = Q30One - udiv((z2 * term) >> 30, dens[k]);
    end
    s  = (z * term) >> 30;
    kt = (KQ30 * t) >> 30;
    if (kt == 0) return '0;
    e = udiv((s << 17) + (kt >> 1), kt);
    if (e > EntryMax) e = EntryMax;
    return e[RomWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scss_lane.sv =====
// ----------------------------------------------------------------------------
// scss_lane
// One channel: highpass with alternating state sets, shaper blend, slew
// limit, gain and saturation, stepped one stage per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_lane
  import scss_pkg::*;
#(
  parameter int SampleWidth = SampleWidthDef,
  parameter int CoeffWidth  = CoeffWidthDef,
  parameter int ShaperDepth = ShaperDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lane_ctl_t                     ctl_i,
  input  wire logic signed [SampleWidth-1:0] sample_i,
  input  wire logic [CoeffWidth-1:0]         hp_coeff_i,
  input  wire logic [SlewWidth-1:0]          slew_i,
  input  wire logic [LevelWidth-1:0]         drive_i,
  input  wire logic [LevelWidth-1:0]         gain_i,
  output logic signed [SampleWidth-1:0]      result_o
);

  localparam int W   = SampleWidth;
  localparam int F   = W - 1;
  localparam int IW  = $clog2(ShaperDepth);
  localparam int SW  = W + 9;
  localparam int DW  = W + 10;
  localparam int P1W = DW + CoeffWidth + 1;
  localparam int RW  = W + 2;
  localparam int MPW = W + IW;
  localparam int BW  = W + 3;
  localparam int P2W = BW + LevelWidth + 1;
  localparam int YW  = W + 3;
  localparam int EW  = ((YW > SlewWidth + 1) ? YW : SlewWidth + 1) + 2;
  localparam int P3W = YW + LevelWidth + 1;

  logic [RomWidth-1:0] rom_w [ShaperDepth];

  for (genvar g = 0; g < ShaperDepth; g++) begin : g_rom
    localparam logic [RomWidth-1:0] Entry = shaper_entry(g, ShaperDepth);
    assign rom_w[g] = Entry;
  end

  logic signed [W-1:0]   x_q;
  logic signed [SW-1:0]  hp_even_q, hp_odd_q;
  logic signed [P1W-1:0] prod1_q;
  logic signed [RW-1:0]  dry_q;
  logic [MPW-1:0]        magp_q;
  logic                  neg_q;
  logic [RomWidth-1:0]   rom_q;
  logic signed [P2W-1:0] prod2_q;
  logic signed [YW-1:0]  prev_q;
  logic signed [YW-1:0]  yv_q;
  logic signed [W-1:0]   out_q;

  logic signed [DW-1:0]      xs;
  logic signed [SW-1:0]      s_sel, s_new;
  logic signed [DW-1:0]      diff1, drywide;
  logic signed [P1W-1:0]     prod1;
  logic signed [RW-1:0]      one_s;
  logic [W-1:0]              mag;
  logic [MPW:0]              idx_sum;
  logic [IW-1:0]             idx;
  logic [RomWidth+F-1:0]     dist_wide;
  logic signed [RW-1:0]      shaped;
  logic signed [BW-1:0]      diff2;
  logic [LevelWidth-1:0]     dsel;
  logic signed [P2W-1:0]     prod2;
  logic signed [EW-1:0]      y_e, p_e, l_e;
  logic signed [P3W-1:0]     prod3;
  logic signed [YW+1:0]      gained;
  logic signed [YW+1:0]      smax, smin;

  always_comb begin
    xs      = DW'(x_q) <<< 8;
    s_sel   = ctl_i.phase ? hp_even_q : hp_odd_q;
    diff1   = xs - DW'(s_sel);
    prod1   = P1W'(diff1) * P1W'($signed({1'b0, hp_coeff_i}));
    s_new   = SW'(DW'(s_sel) + DW'(prod1_q >>> CoeffWidth));
    drywide = (xs - DW'(s_new)) >>> 8;

    one_s = RW'(1) <<< F;
    if (dry_q > one_s || dry_q < -one_s) begin
      mag = W'(1) << F;
    end else if (dry_q < 0) begin
      mag = W'(-dry_q);
    end else begin
      mag = W'(dry_q);
    end

    idx_sum = (MPW+1)'(magp_q) + ((MPW+1)'(1) << (F-1));
    idx     = idx_sum[F+IW-1:F];

    dist_wide = (RomWidth+F)'(rom_q) << F;
    shaped    = $signed(RW'(dist_wide[RomWidth+F-1:17]));
    if (neg_q) shaped = -shaped;
    diff2 = BW'(shaped) - BW'(dry_q);
    dsel  = (drive_i > Unity) ? Unity : drive_i;
    prod2 = P2W'(diff2) * P2W'($signed({1'b0, dsel}));

    y_e = EW'(BW'(dry_q) + BW'(prod2_q >>> 16));
    p_e = EW'(prev_q);
    l_e = $signed(EW'(slew_i));
    if (y_e - p_e > l_e) begin
      y_e = p_e + l_e;
    end else if (p_e - y_e > l_e) begin
      y_e = p_e - l_e;
    end

    prod3 = P3W'(yv_q) * P3W'($signed({1'b0, gain_i}));
    if (gain_i < Unity) begin
      gained = (YW+2)'(prod3 >>> 16);
    end else begin
      gained = (YW+2)'(yv_q);
    end
    smax = (YW+2)'(1) <<< F;
    smax = smax - (YW+2)'(1);
    smin = -smax - (YW+2)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_even_q <= '0;
      hp_odd_q  <= '0;
      prev_q    <= '0;
    end else if (ctl_i.run) begin
      if (ctl_i.step == STEP_HP) begin
        if (ctl_i.phase) hp_even_q <= s_new;
        else             hp_odd_q  <= s_new;
      end
      if (ctl_i.step == STEP_SLEW) prev_q <= YW'(y_e);
    end
  end

  // datapath registers, stepped by the shared sequencer
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) x_q <= sample_i;
    if (ctl_i.run) begin
      case (ctl_i.step)
        STEP_MUL_HP: prod1_q <= prod1;
        STEP_HP:     dry_q   <= RW'(drywide);
        STEP_IDX: begin
          magp_q <= MPW'(mag) * MPW'(ShaperDepth - 1);
          neg_q  <= dry_q < 0;
        end
        STEP_ROM:    rom_q   <= rom_w[idx];
        STEP_BLEND:  prod2_q <= prod2;
        STEP_SLEW:   yv_q    <= YW'(y_e);
        STEP_GAIN: begin
          if (gained > smax)      out_q <= W'(smax);
          else if (gained < smin) out_q <= W'(smin);
          else                    out_q <= W'(gained);
        end
        default: ;
      endcase
    end
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/scss_merge.sv =====
// ----------------------------------------------------------------------------
// scss_merge
// Joins the two lane results into one frame and holds it on the output
// channel until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_merge
  import scss_pkg::*;
#(
  parameter int SampleWidth = SampleWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic signed [SampleWidth-1:0] left_i,
  input  wire logic signed [SampleWidth-1:0] right_i,
  input  wire logic                         ready_i,
  output logic                              valid_o,
  output logic [2*SampleWidth-1:0]          data_o
);

  logic                     valid_q;
  logic [2*SampleWidth-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= {right_i, left_i};
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/stereo_channel_strip_saturator_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_channel_strip_saturator_unit
// Stereo highpass, shaper blend, slew limit and gain on q1.23 frames, one
// lane per channel.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | tdata: left_sample, right_sample
//  m_axis   | out | tdata: left_out, right_out
//  cfg      | in  | cfg_idx_i register index, cfg_data_i value
//
//  after accept a frame runs seven lane steps, then the output register load;
//  the input turns ready in the same cycle that the result turns valid, and
//  frames go one at a time through the lanes.
//  a finished frame waits in the output register, so the next frame is taken
//  while it is stalled; the lanes hold at their last step if it is still full.
//  reset clears highpass and slew state and selects the even state set.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_channel_strip_saturator_unit
  import scss_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = SampleWidthDef,
  parameter int COEFF_WIDTH        = CoeffWidthDef,
  parameter int SHAPER_TABLE_DEPTH = ShaperDepthDef,
  localparam int DataWidth         = ((2*SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // left_sample, right_sample, zero fill
  input  wire logic [DataWidth-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // left_out, right_out, zero fill
  output logic [DataWidth-1:0]         m_axis_tdata,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int W = SAMPLE_WIDTH;

  logic [COEFF_WIDTH-1:0] hp_coeff_q;
  logic [SlewWidth-1:0]   slew_q;
  logic [LevelWidth-1:0]  drive_q, gain_q;
  logic                   busy_q, phase_q;
  step_e                  step_q;
  lane_ctl_t              ctl;
  logic                   accept, finish;
  logic signed [W-1:0]    left_res, right_res;
  logic [2*W-1:0]         out_data;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q;
  assign finish        = busy_q && step_q == STEP_DONE && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    ctl.load  = accept;
    ctl.run   = busy_q;
    ctl.step  = step_q;
    ctl.phase = phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_coeff_q <= COEFF_WIDTH'(HpCoeffRst);
      slew_q     <= SlewRst;
      drive_q    <= DriveRst;
      gain_q     <= GainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HP_COEFF: hp_coeff_q <= cfg_data_i[COEFF_WIDTH-1:0];
        CFG_SLEW:     slew_q     <= cfg_data_i[SlewWidth-1:0];
        CFG_DRIVE:    drive_q    <= cfg_data_i[LevelWidth-1:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= STEP_MUL_HP;
      phase_q <= 1'b1;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= STEP_MUL_HP;
    end else if (finish) begin
      busy_q  <= 1'b0;
      phase_q <= !phase_q;
    end else if (busy_q && step_q != STEP_DONE) begin
      step_q <= step_e'(step_q + 3'd1);
    end
  end

  scss_lane #(
    .SampleWidth(W), .CoeffWidth(COEFF_WIDTH), .ShaperDepth(SHAPER_TABLE_DEPTH)
  ) u_lane_left (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .sample_i(s_axis_tdata[W-1:0]),
    .hp_coeff_i(hp_coeff_q), .slew_i(slew_q), .drive_i(drive_q), .gain_i(gain_q),
    .result_o(left_res)
  );

  scss_lane #(
    .SampleWidth(W), .CoeffWidth(COEFF_WIDTH), .ShaperDepth(SHAPER_TABLE_DEPTH)
  ) u_lane_right (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .sample_i(s_axis_tdata[2*W-1:W]),
    .hp_coeff_i(hp_coeff_q), .slew_i(slew_q), .drive_i(drive_q), .gain_i(gain_q),
    .result_o(right_res)
  );

  scss_merge #(.SampleWidth(W)) u_merge (
    .clk_i, .rst_ni,
    .load_i(finish), .left_i(left_res), .right_i(right_res),
    .ready_i(m_axis_tready), .valid_o(m_axis_tvalid), .data_o(out_data)
  );

  assign m_axis_tdata = DataWidth'(out_data);

  // accepted frame starts the sequencer at its first step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && step_q == STEP_MUL_HP)
    else $error("sequencer did not start on accepted frame");

  // a finished frame always shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid && !busy_q)
    else $error("finished frame not presented");

  // lanes never hand off into an occupied, stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !finish)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== dv/stereo_channel_strip_saturator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_channel_strip_saturator_unit_tb
// Drives stereo frames through the saturator and checks every output frame
// against a cycle-free model of the highpass, shaper blend, slew limiter and
// gain, under random stalls on both streams and a long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_channel_strip_saturator_unit_tb;
  import scss_pkg::*;

  localparam int Frac    = 23;
  localparam int RomSize = 1024;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // left_sample, right_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // left_out, right_out
  logic        cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  stereo_channel_strip_saturator_unit dut (.*);

  // model state
  longint unsigned shape_tab [RomSize];
  longint hp_state [2][2];        // [channel][set], set 0 = even
  longint prev_out [2];
  bit     even_next;
  longint unsigned hp_coeff, slew_lim, density, out_gain;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;
  frame_t pending_frames [$];

  int  n_frames, n_checked, n_errors;
  bit  quiet, hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned shape_value(longint unsigned i);
    longint unsigned t, p, z, z2, term, s, kt, e;
    longint unsigned dv [5];
    dv = '{110, 72, 42, 20, 6};
    if (i == 0) return 0;
    t  = (i << 30) / (RomSize - 1);
    p  = (t * t) >> 30;
    z  = (64'd1686629713 * p) >> 30;
    z2 = (z * z) >> 30;
    term = 64'd1 << 30;
    for (int k = 0; k < 5; k++) term = (64'd1 << 30) - ((z2 * term) >> 30) / dv[k];
    s  = (z * term) >> 30;
    kt = (64'd1345735808 * t) >> 30;
    if (kt == 0) return 0;
    e = ((s << 17) + kt / 2) / kt;
    return (e > 262143) ? 262143 : e;
  endfunction

  function automatic logic signed [23:0] strip_channel(longint x, int ch, int set);
    longint xs, s, dry, c, shp, y, d, lim;
    longint unsigned mag, idx;
    xs = x * 256;
    s  = hp_state[ch][set];
    s  = s + (((xs - s) * longint'(hp_coeff)) >>> 16);
    hp_state[ch][set] = s;
    dry = (xs - s) >>> 8;
    c = dry;
    if (c > (64'sd1 <<< Frac)) c = 64'sd1 <<< Frac;
    if (c < -(64'sd1 <<< Frac)) c = -(64'sd1 <<< Frac);
    mag = (c < 0) ? -c : c;
    idx = (mag * (RomSize - 1) + (64'd1 << (Frac - 1))) >> Frac;
    if (idx > RomSize - 1) idx = RomSize - 1;
    shp = longint'((shape_tab[idx] << Frac) >> 17);
    if (c < 0) shp = -shp;
    d = (density > 65536) ? 65536 : longint'(density);
    y = dry + (((shp - dry) * d) >>> 16);
    lim = longint'(slew_lim);
    if (y - prev_out[ch] > lim) y = prev_out[ch] + lim;
    if (prev_out[ch] - y > lim) y = prev_out[ch] - lim;
    prev_out[ch] = y;
    if (out_gain < 65536) y = (y * longint'(out_gain)) >>> 16;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[23:0];
  endfunction

  function automatic void predict_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_t f;
    int set;
    set = even_next ? 0 : 1;
    f.left  = strip_channel(longint'(l), 0, set);
    f.right = strip_channel(longint'(r), 1, set);
    even_next = ~even_next;
    pending_frames.push_back(f);
  endfunction

  // output checker
  always @(posedge clk_i) begin
    frame_t f;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected output transfer %h", m_axis_tdata);
        n_errors++;
      end else begin
        f = pending_frames.pop_front();
        n_checked++;
        if (m_axis_tdata[23:0] !== f.left) begin
          $error("left_out: expected %0d actual %0d", f.left, $signed(m_axis_tdata[23:0]));
          n_errors++;
        end
        if (m_axis_tdata[47:24] !== f.right) begin
          $error("right_out: expected %0d actual %0d", f.right,
                 $signed(m_axis_tdata[47:24]));
          n_errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, or one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tdata  = {r, l};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(l, r);
    n_frames++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_HP_COEFF: hp_coeff = val[15:0];
      CFG_SLEW:     slew_lim = val;
      CFG_DRIVE:    density  = val[16:0];
      default:      out_gain = val[16:0];
    endcase
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      1:       return 24'($signed($urandom_range(0, 4095)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_extremes;
    // full drive, no highpass smoothing, both phases hit
    write_reg(CFG_DRIVE, 24'd65536);
    write_reg(CFG_HP_COEFF, 24'd0);
    send_frame(24'sh7fffff, 24'sh800000);
    send_frame(24'sh800000, 24'sh7fffff);
    send_frame(24'sd0, 24'sd0);
    send_frame(24'sd1, -24'sd1);
    drain();
    // density above unity, max coefficient with dropped high bits
    write_reg(CFG_DRIVE, 24'h1ffff);
    write_reg(CFG_HP_COEFF, 24'hffffff);
    send_frame(24'sh400000, -24'sh400000);
    send_frame(24'sh7fffff, 24'sh7fffff);
    send_frame(24'sh800000, 24'sh800000);
    drain();
    // zero slew holds the output, gain below unity and zero gain
    write_reg(CFG_SLEW, 24'd0);
    write_reg(CFG_GAIN, 24'd32768);
    send_frame(24'sh123456, -24'sh123456);
    send_frame(24'sh7fffff, 24'sh800000);
    drain();
    write_reg(CFG_SLEW, 24'hffffff);
    write_reg(CFG_GAIN, 24'd0);
    send_frame(24'sh7fffff, 24'sh800000);
    drain();
    write_reg(CFG_GAIN, 24'h1ffff);
    write_reg(CFG_SLEW, 24'd1000);
    send_frame(24'sh7fffff, 24'sh800000);
    send_frame(24'sh800000, 24'sh7fffff);
    drain();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(CFG_HP_COEFF, 24'($urandom));
      write_reg(CFG_SLEW, $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 20000))
                                                    : 24'($urandom));
      write_reg(CFG_DRIVE, 24'($urandom_range(0, 131071)));
      write_reg(CFG_GAIN, 24'($urandom_range(0, 131071)));
      for (int i = 0; i < per_phase; i++) send_frame(rand_sample(), rand_sample());
      drain();
    end
  endtask

  task automatic test_output_hold;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_frame(rand_sample(), rand_sample());
    drain();
  endtask

  initial begin
    for (int i = 0; i < RomSize; i++) shape_tab[i] = shape_value(i);
    hp_state   = '{'{0, 0}, '{0, 0}};
    prev_out   = '{0, 0};
    even_next  = 1'b1;
    hp_coeff   = 655;
    slew_lim   = 8388607;
    density    = 0;
    out_gain   = 65536;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HP_COEFF;
    cfg_data_i    = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_random_settings(10, 30);
    test_output_hold();
    quiet = 1'b1;
    test_random_settings(4, 30);

    $display("frames sent %0d, frames checked %0d, over directed extremes,", n_frames,
             n_checked);
    $display("random register settings, a long output hold and an unstalled tail");
    if (n_errors == 0 && pending_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/scss_pkg.sv
rtl/scss_lane.sv
rtl/scss_merge.sv
rtl/stereo_channel_strip_saturator_unit.sv
dv/stereo_channel_strip_saturator_unit_tb.sv
